// ----- sv/clp_pkg.sv -----
// clp_pkg: shared types and constants of the colon command line parser
// no dependencies; imported by clp_core, colon_command_line_parser_unit, clp_checker and tb_top
package clp_pkg;

  localparam logic [7:0] NewlineChar = 8'h0A;
  localparam logic [7:0] ColonChar   = 8'h3A;
  localparam logic [7:0] ZeroChar    = 8'h30;
  localparam logic [7:0] NineChar    = 8'h39;
  localparam logic [7:0] PlusChar    = 8'h2B;
  localparam logic [7:0] MinusChar   = 8'h2D;
  localparam logic [3:0] Radix       = 4'd10;

  localparam logic [7:0] LineLimitReset = 8'd32;
  localparam int unsigned CfgAddrW      = 3;

  // register indexes of the configuration port
  localparam logic RegLineLimit = 1'b0;

  localparam logic [31:0] MagCap    = 32'h8000_0000;
  localparam logic [31:0] PosMaxVal = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_COLON,
    PH_LEAD,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } clp_phase_t;

  typedef struct packed {
    logic        line_status;
    logic [7:0]  command_char;
    logic [1:0]  matched;
    logic [15:0] value_b;
    logic [31:0] value_c;
  } clp_result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage

// ----- sv/clp_core.sv -----
// clp_core: line state and the one-byte update of the parser
// depends on clp_pkg
module clp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          line_limit,
  output logic                has_result,
  output clp_pkg::clp_result_t result
);
  import clp_pkg::*;

  clp_phase_t  phase_r, phase_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [31:0] magnitude_r, magnitude_nxt;
  logic        negative_r, negative_nxt;
  logic [7:0]  cmd_byte_r, cmd_byte_nxt;
  logic [15:0] held_b_r, held_b_nxt;
  logic [1:0]  match_count_r, match_count_nxt;

  logic        is_nl, is_digit, do_end, end_to_c, do_digit;
  logic [31:0] field_val, digit_mag;
  logic [35:0] mag_x10;
  logic [8:0]  count_inc, limit9;

  // strtol-style value: negation wraps, positive side clamps
  assign field_val = negative_r ? (32'd0 - magnitude_r)
                                : (magnitude_r[31] ? PosMaxVal : magnitude_r);

  // multiply by ten as two shifts and an add, then cap
  assign mag_x10 = ({4'd0, magnitude_r} << 3) + ({4'd0, magnitude_r} << 1)
                 + {32'd0, rx_byte[3:0] - ZeroChar[3:0]};
  assign digit_mag = (mag_x10 > {4'd0, MagCap}) ? MagCap : mag_x10[31:0];

  assign is_nl    = (rx_byte == NewlineChar);
  assign is_digit = (rx_byte >= ZeroChar) && (rx_byte <= NineChar);
  assign count_inc = {1'b0, byte_count_r} + 9'd1;
  assign limit9    = (line_limit == 8'd0) ? 9'd1 : {1'b0, line_limit};

  always_comb begin
    phase_nxt       = phase_r;
    byte_count_nxt  = byte_count_r;
    magnitude_nxt   = magnitude_r;
    negative_nxt    = negative_r;
    cmd_byte_nxt    = cmd_byte_r;
    held_b_nxt      = held_b_r;
    match_count_nxt = match_count_r;
    has_result      = 1'b0;
    result          = '0;
    do_end          = 1'b0;
    end_to_c        = 1'b0;
    do_digit        = 1'b0;

    if (is_nl) begin
      has_result          = 1'b1;
      result.command_char = cmd_byte_r;
      result.matched      = (match_count_r == 2'd0) ? 2'd1 : match_count_r;
      if (match_count_r == 2'd2) begin
        result.value_b = (phase_r == PH_DONE) ? held_b_r : field_val[15:0];
      end else if (match_count_r == 2'd3) begin
        result.value_b = held_b_r;
        result.value_c = field_val;
      end
    end else begin
      unique case (phase_r)
        PH_CMD: begin
          cmd_byte_nxt    = rx_byte;
          match_count_nxt = 2'd1;
          phase_nxt       = PH_COLON;
        end
        PH_COLON: begin
          if (rx_byte == ColonChar) begin
            match_count_nxt = 2'd2;
            magnitude_nxt   = '0;
            negative_nxt    = 1'b0;
            phase_nxt       = PH_LEAD;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_LEAD: begin
          // empty b field: colon straight after the first colon
          if (match_count_r == 2'd2 && byte_count_r == 8'd2 && rx_byte == ColonChar) begin
            do_end   = 1'b1;
            end_to_c = 1'b1;
          end else if (is_space(rx_byte)) begin
            phase_nxt = PH_LEAD;
          end else if (rx_byte == PlusChar || rx_byte == MinusChar) begin
            negative_nxt = (rx_byte == MinusChar);
            phase_nxt    = PH_SIGN;
          end else if (is_digit) begin
            do_digit = 1'b1;
          end else begin
            do_end = 1'b1;
          end
        end
        PH_SIGN: begin
          if (is_digit) do_digit = 1'b1;
          else          do_end   = 1'b1;
        end
        PH_DIGIT: begin
          if (is_digit) begin
            do_digit = 1'b1;
          end else begin
            do_end   = 1'b1;
            end_to_c = (rx_byte == ColonChar);
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase

      if (do_digit) begin
        magnitude_nxt = digit_mag;
        phase_nxt     = PH_DIGIT;
      end

      if (do_end) begin
        phase_nxt = PH_DONE;
        if (match_count_r == 2'd2) begin
          held_b_nxt = field_val[15:0];
          if (end_to_c) begin
            match_count_nxt = 2'd3;
            magnitude_nxt   = '0;
            negative_nxt    = 1'b0;
            phase_nxt       = PH_LEAD;
          end
        end
      end

      byte_count_nxt = count_inc[7:0];
      if (count_inc >= limit9) begin
        has_result         = 1'b1;
        result.line_status = 1'b1;
      end
    end

    // a result of either kind starts a fresh line
    if (has_result) begin
      phase_nxt       = PH_CMD;
      byte_count_nxt  = '0;
      magnitude_nxt   = '0;
      negative_nxt    = 1'b0;
      cmd_byte_nxt    = '0;
      held_b_nxt      = '0;
      match_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_CMD;
      byte_count_r  <= '0;
      magnitude_r   <= '0;
      negative_r    <= 1'b0;
      cmd_byte_r    <= '0;
      held_b_r      <= '0;
      match_count_r <= '0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      byte_count_r  <= byte_count_nxt;
      magnitude_r   <= magnitude_nxt;
      negative_r    <= negative_nxt;
      cmd_byte_r    <= cmd_byte_nxt;
      held_b_r      <= held_b_nxt;
      match_count_r <= match_count_nxt;
    end
  end

endmodule

// ----- sv/colon_command_line_parser_unit.sv -----
// colon_command_line_parser_unit: top level with input register, result register and apb port
// depends on clp_pkg and clp_core
//
// usage
// - input channel: one received byte per word on in_rx_byte (in_valid / in_ready)
// - result channel: one word per finished line or per overflow (out_valid / out_ready)
//   carrying line_status, command_char, matched, value_b and value_c
// - apb port: register 0 at byte address 0 is line_limit (8 bits, reset 32),
//   pready is always high, writes only while the block is idle
// throughput: one byte per cycle, less when out_ready holds a result back; set by the
//   combinational parser update between the input register and the result register
// path: the newline or the limit-reaching byte is taken into the input register, and the
//   parser's result is loaded into the result register, raising out_valid, when that register is free
// reset: synchronous active-low rst_n empties both registers, returns the parser
//   to the start of a line and restores line_limit to 32
// stall: while a result waits on out_ready, bytes that give no result keep moving;
//   a byte that would give a second result holds in the input register, and
//   in_ready drops only once that register is also held
module colon_command_line_parser_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // byte input
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_rx_byte,
  // result output
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_line_status,
  output logic [7:0]                 out_command_char,
  output logic [1:0]                 out_matched,
  output logic signed [15:0]         out_value_b,
  output logic signed [31:0]         out_value_c,
  // configuration
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [clp_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import clp_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_adv, out_free, has_result;
  logic        out_valid_r;
  clp_result_t out_r, core_result;
  logic [7:0]  line_limit_r;
  logic        cfg_wr;

  // apb: register index sits above the word offset
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == RegLineLimit) ? {24'd0, line_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= LineLimitReset;
    end else if (cfg_wr && cfg_paddr[2] == RegLineLimit) begin
      line_limit_r <= cfg_pwdata[7:0];
    end
  end

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;
  // a byte with no result never needs the result register
  assign s1_adv   = s1_valid_r && (!has_result || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  clp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (s1_adv),
    .rx_byte    (s1_byte_r),
    .line_limit (line_limit_r),
    .has_result (has_result),
    .result     (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_result) begin
      out_r <= core_result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_status  = out_r.line_status;
  assign out_command_char = out_r.command_char;
  assign out_matched      = out_r.matched;
  assign out_value_b      = out_r.value_b;
  assign out_value_c      = out_r.value_c;

endmodule

// ----- sv/clp_checker.sv -----
// clp_checker: port-level assertions on the result channel, bound to the top level
// depends on clp_pkg and colon_command_line_parser_unit
module clp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_line_status,
  input logic [7:0]         out_command_char,
  input logic [1:0]         out_matched,
  input logic signed [15:0] out_value_b,
  input logic signed [31:0] out_value_c
);
  import clp_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_status)
      && $stable(out_command_char) && $stable(out_matched)
      && $stable(out_value_b) && $stable(out_value_c))
    else $error("result word changed while stalled");

  // overflow word carries nothing else
  a_overflow_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_status |-> out_matched == 2'd0 && out_command_char == 8'd0
      && out_value_b == 16'sd0 && out_value_c == 32'sd0)
    else $error("overflow word with non-zero fields");

  // a parsed line always matches at least the command
  a_line_matched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_status |-> out_matched != 2'd0)
    else $error("parsed line with no match");

  // unmatched fields read as zero
  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_status && out_matched != 2'd3 |->
      out_value_c == 32'sd0 && (out_matched != 2'd1 || out_value_b == 16'sd0))
    else $error("unmatched field not zero");

endmodule

bind colon_command_line_parser_unit clp_checker u_clp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_line_status  (out_line_status),
  .out_command_char (out_command_char),
  .out_matched      (out_matched),
  .out_value_b      (out_value_b),
  .out_value_c      (out_value_c)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking bench for the colon command line parser unit
// drives bytes, apb writes and result back-pressure, checks against its own line predictor
// depends on clp_pkg and colon_command_line_parser_unit
module tb_top;
  import clp_pkg::*;

  // address of the line limit register on the apb port
  localparam logic [CfgAddrW-1:0] LimitAddr = CfgAddrW'(4 * RegLineLimit);
  // the five whitespace bytes that a number may start with
  localparam logic [39:0] BlankChars = {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
  localparam int SettleCycles = 6;
  localparam int SegmentBytes = 215;

  // kinds of row in the directed plan
  typedef enum logic {RowByte, RowLimit} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;
    logic        typed;
    clp_result_t want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_rx_byte;
  logic out_valid;
  logic out_ready;
  logic out_line_status;
  logic [7:0] out_command_char;
  logic [1:0] out_matched;
  logic signed [15:0] out_value_b;
  logic signed [31:0] out_value_c;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // predictor state: where we are in the line and the number being built
  clp_phase_t  line_phase;
  logic [7:0]  line_bytes;
  logic [31:0] accum;
  logic        accum_neg;
  logic [7:0]  line_cmd;
  logic [15:0] kept_b;
  logic [1:0]  fields_seen;
  logic [7:0]  limit_setting;

  clp_result_t awaited_lines[$];   // expected results, oldest first
  clp_result_t oldest_line;
  logic [7:0]  line_text[$];       // bytes of the random line being built
  plan_row_t   walk_plan [24];
  int          mismatches;
  int          bytes_sent;
  int          send_idle_pct;
  int          recv_idle_pct;

  colon_command_line_parser_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_status  (out_line_status),
    .out_command_char (out_command_char),
    .out_matched      (out_matched),
    .out_value_b      (out_value_b),
    .out_value_c      (out_value_c),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // line predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_blank(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 5; i++) begin
      if (c == BlankChars[8*i +: 8]) hit = 1'b1;
    end
    return hit;
  endfunction

  // signed view of the number so far, clamped on the positive side only
  function automatic logic [31:0] accum_value();
    if (accum_neg) return 32'd0 - accum;
    return (accum > PosMaxVal) ? PosMaxVal : accum;
  endfunction

  task automatic clear_accum();
    accum = '0;
    accum_neg = 1'b0;
  endtask

  task automatic reset_line();
    line_phase = PH_CMD;
    line_bytes = '0;
    line_cmd = '0;
    kept_b = '0;
    fields_seen = '0;
    clear_accum();
  endtask

  // multiply-by-ten accumulate, magnitude capped at 2^31
  task automatic push_digit(input logic [7:0] c);
    logic [63:0] t;
    t = 64'(accum) * 64'(Radix) + 64'(c - ZeroChar);
    if (t > 64'(MagCap)) t = 64'(MagCap);
    accum = t[31:0];
    line_phase = PH_DIGIT;
  endtask

  // the number in progress ends; a colon after b moves on to c
  task automatic close_field(input logic to_c);
    logic [31:0] fv;
    fv = accum_value();
    if (fields_seen == 2'd2) begin
      kept_b = fv[15:0];
      if (to_c) begin
        fields_seen = 2'd3;
        clear_accum();
        line_phase = PH_LEAD;
        return;
      end
    end
    line_phase = PH_DONE;
  endtask

  // one accepted byte in, at most one result out
  task automatic parse_byte(input logic [7:0] c, output logic got, output clp_result_t res);
    logic        is_digit;
    logic [7:0]  cap;
    logic [31:0] fv;
    got = 1'b0;
    res = '0;
    fv = accum_value();
    if (c == NewlineChar) begin
      res.command_char = line_cmd;
      res.matched = (fields_seen == 2'd0) ? 2'd1 : fields_seen;
      if (fields_seen == 2'd2) begin
        res.value_b = (line_phase == PH_DONE) ? kept_b : fv[15:0];
      end else if (fields_seen == 2'd3) begin
        res.value_b = kept_b;
        res.value_c = fv;
      end
      got = 1'b1;
      reset_line();
      return;
    end
    is_digit = (c >= ZeroChar) && (c <= NineChar);
    case (line_phase)
      PH_CMD: begin
        line_cmd = c;
        fields_seen = 2'd1;
        line_phase = PH_COLON;
      end
      PH_COLON: begin
        if (c == ColonChar) begin
          fields_seen = 2'd2;
          clear_accum();
          line_phase = PH_LEAD;
        end else begin
          line_phase = PH_DONE;
        end
      end
      PH_LEAD: begin
        // a colon straight after the first colon means an empty b field
        if (fields_seen == 2'd2 && line_bytes == 8'd2 && c == ColonChar) begin
          close_field(1'b1);
        end else if (is_blank(c)) begin
          // leading whitespace is skipped
        end else if (c == PlusChar || c == MinusChar) begin
          accum_neg = (c == MinusChar);
          line_phase = PH_SIGN;
        end else if (is_digit) begin
          push_digit(c);
        end else begin
          close_field(1'b0);
        end
      end
      PH_SIGN: begin
        if (is_digit) push_digit(c);
        else close_field(1'b0);
      end
      PH_DIGIT: begin
        if (is_digit) push_digit(c);
        else close_field(c == ColonChar);
      end
      default: begin
      end
    endcase
    line_bytes = line_bytes + 8'd1;
    // a limit of zero behaves as one
    cap = (limit_setting == 8'd0) ? 8'd1 : limit_setting;
    if (line_bytes >= cap) begin
      got = 1'b1;
      res.line_status = 1'b1;
      reset_line();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, seen);
    end
  endtask

  // every result word taken is held against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_lines.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result word, expected none actual %b %h %0d %h %h",
                 $time, out_line_status, out_command_char, out_matched, out_value_b,
                 out_value_c);
      end else begin
        oldest_line = awaited_lines.pop_front();
        check_field("line_status", 32'(oldest_line.line_status), 32'(out_line_status));
        check_field("command_char", 32'(oldest_line.command_char), 32'(out_command_char));
        check_field("matched", 32'(oldest_line.matched), 32'(out_matched));
        check_field("value_b", {16'h0, oldest_line.value_b}, {16'h0, out_value_b});
        check_field("value_c", oldest_line.value_c, out_value_c);
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offers one byte, with random idle cycles first; returns in the step of acceptance
  task automatic send_byte(input logic [7:0] b, output logic got, output clp_result_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    parse_byte(b, got, res);
  endtask

  // lets every expected word out and the pipe run empty before a register write
  task automatic drain_and_wait();
    in_valid <= 1'b0;
    while (awaited_lines.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // apb write of line_limit, then a read back of the same register
  task automatic write_limit(input logic [7:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= LimitAddr;
    cfg_pwdata <= {24'h0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    limit_setting = v;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    check_field("line_limit read back", {24'h0, v}, cfg_prdata);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // random line builder
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == NewlineChar) ? 8'h7E : b;
  endfunction

  // whitespace, sign and digits of one field, any part of it possibly missing
  task automatic add_number();
    logic [63:0] mag;
    logic [7:0]  rev[$];
    int          k;
    if ($urandom_range(0, 99) < 25) begin
      repeat ($urandom_range(1, 2)) line_text.push_back(BlankChars[8*$urandom_range(0, 4) +: 8]);
    end
    k = $urandom_range(0, 99);
    if (k < 33) line_text.push_back(MinusChar);
    else if (k < 48) line_text.push_back(PlusChar);
    k = $urandom_range(0, 99);
    if (k < 10) return;    // no digits at all
    if (k < 45) begin
      mag = 64'($urandom_range(0, 999));
    end else if (k < 65) begin
      mag = 64'($urandom);
    end else if (k < 80) begin
      // values around the 16 and 32 bit boundaries
      case ($urandom_range(0, 5))
        0: mag = 64'd32767;
        1: mag = 64'd65536;
        2: mag = 64'd2147483647;
        3: mag = 64'd2147483648;
        4: mag = 64'd2147483649;
        default: mag = 64'd4294967296;
      endcase
    end else begin
      mag = {$urandom, $urandom} % 64'd1_000_000_000_000;
    end
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 3)) line_text.push_back(ZeroChar);
    end
    do begin
      rev.push_back(ZeroChar + 8'(mag % 64'd10));
      mag = mag / 64'd10;
    end while (mag != 0);
    while (rev.size() != 0) line_text.push_back(rev.pop_back());
  endtask

  // mostly well-formed c:b:c lines with random content, some noise and broken lines
  task automatic send_random_line();
    logic        got;
    clp_result_t res;
    int          k;
    line_text.delete();
    k = $urandom_range(0, 99);
    if (k < 10) begin
      repeat ($urandom_range(1, 24)) line_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      line_text.push_back(text_byte());
      if (k < 16) line_text.push_back(text_byte());
      else line_text.push_back(ColonChar);
      add_number();
      if ($urandom_range(0, 99) < 80) line_text.push_back(ColonChar);
      else line_text.push_back(text_byte());
      add_number();
      repeat ($urandom_range(0, 3)) line_text.push_back(text_byte());
      // now and then no newline, so the next line runs on into this one
      if ($urandom_range(0, 99) < 95) line_text.push_back(NewlineChar);
    end
    foreach (line_text[i]) begin
      send_byte(line_text[i], got, res);
      if (got) awaited_lines.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed plan rows
  // ---------------------------------------------------------------------------

  function automatic plan_row_t byte_row(input logic [7:0] d);
    return '{kind: RowByte, data: d, typed: 1'b0, want: '0};
  endfunction

  function automatic plan_row_t typed_row(input logic [7:0] d, input logic st,
                                          input logic [7:0] cmd, input logic [1:0] m,
                                          input logic [15:0] b);
    return '{kind: RowByte, data: d, typed: 1'b1,
             want: '{line_status: st, command_char: cmd, matched: m, value_b: b, value_c: '0}};
  endfunction

  function automatic plan_row_t limit_row(input logic [7:0] v);
    return '{kind: RowLimit, data: v, typed: 1'b0, want: '0};
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic        got;
    clp_result_t res;
    int          seg_start;
    logic [7:0]  lim;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    bytes_sent = 0;
    send_idle_pct = 30;
    recv_idle_pct = 61;
    limit_setting = LineLimitReset;
    reset_line();

    walk_plan = '{
      // a lone newline: empty line, command 0
      typed_row(NewlineChar, 1'b0, 8'h00, 2'd1, 16'h0000),
      // zero byte as the command
      byte_row(8'h00),
      typed_row(NewlineChar, 1'b0, 8'h00, 2'd1, 16'h0000),
      // top byte as the command, nothing else
      byte_row(8'hFF),
      typed_row(NewlineChar, 1'b0, 8'hFF, 2'd1, 16'h0000),
      // empty b field, then c as a sign with no digits
      byte_row("a"), byte_row(ColonChar), byte_row(ColonChar), byte_row(MinusChar),
      typed_row(NewlineChar, 1'b0, "a", 2'd3, 16'h0000),
      // b as a lone sign: b is 0 and the line stops at two fields
      byte_row("d"), byte_row(ColonChar), byte_row(PlusChar),
      typed_row(NewlineChar, 1'b0, "d", 2'd2, 16'h0000),
      // tab before a negative b, trailing text after it
      byte_row("b"), byte_row(ColonChar), byte_row(8'h09), byte_row(MinusChar),
      byte_row("5"), byte_row("x"),
      typed_row(NewlineChar, 1'b0, "b", 2'd2, 16'hFFFB),
      // a limit of zero: any byte but newline overflows at once
      limit_row(8'd0),
      typed_row("q", 1'b1, 8'h00, 2'd0, 16'h0000),
      typed_row(NewlineChar, 1'b0, 8'h00, 2'd1, 16'h0000)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words, with the first idling mix
    foreach (walk_plan[i]) begin
      if (walk_plan[i].kind == RowLimit) begin
        drain_and_wait();
        write_limit(walk_plan[i].data);
      end else begin
        send_byte(walk_plan[i].data, got, res);
        if (walk_plan[i].typed) awaited_lines.push_back(walk_plan[i].want);
        else if (got) awaited_lines.push_back(res);
      end
    end

    // random lines in six stretches: limit extremes and mid values,
    // receiver-heavy idling, then sender-heavy, then none
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: lim = 8'd255;
        1: lim = 8'd1;
        2: lim = 8'($urandom_range(2, 40));
        3: lim = 8'd20;
        4: lim = 8'($urandom_range(41, 254));
        default: lim = LineLimitReset;
      endcase
      drain_and_wait();
      if (seg < 2) begin
        send_idle_pct = 30;
        recv_idle_pct = 61;
      end else if (seg < 4) begin
        send_idle_pct = 61;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_limit(lim);
      seg_start = bytes_sent;
      while (bytes_sent - seg_start < SegmentBytes) send_random_line();
    end

    drain_and_wait();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop, well beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- colon_command_line_parser_unit.f -----
sv/clp_pkg.sv
sv/clp_core.sv
sv/colon_command_line_parser_unit.sv
sv/clp_checker.sv
test/tb_top.sv
